[hw/rtl/des_pkg.sv]
package des_pkg;

    localparam int CNT_W      = 16;
    localparam int TIME_W     = 32;
    localparam int CPR_W      = 16;
    localparam int MINI_W     = 10;
    localparam int CIRC_W     = 20;
    localparam int SPEED_W    = 32;
    localparam int DIST_W     = 48;
    localparam int DEN_W      = CPR_W + TIME_W;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 20;
    localparam int IN_DATA_W  = TIME_W + 2 * CNT_W;
    localparam int OUT_DATA_W = 2 * SPEED_W + 2 * DIST_W;

    localparam int SPEED_FRAC_BITS_DEF = 8;
    localparam int SUM_WIDTH_DEF       = 40;

    // 60 s per minute times 1000 ms per second
    localparam int                   RPM_SCALE_W = 16;
    localparam logic [RPM_SCALE_W-1:0] RPM_SCALE = 16'd60000;

    localparam logic [CPR_W-1:0]  CPR_RST      = 16'd30000;
    localparam logic [MINI_W-1:0] MINI_RST     = 10'd10;
    localparam logic [CIRC_W-1:0] CIRC_RST     = 20'd204203;
    localparam logic              INV_RST      = 1'b1;
    localparam logic [CNT_W-1:0]  LAST_CNT_RST = 16'd32767;

    localparam logic OP_CLEAR = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CPR      = 4'd0,
        CFG_MIN_INT  = 4'd1,
        CFG_CIRC     = 4'd2,
        CFG_INV_LEFT = 4'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SPD_MUL,
        ST_SPD_START,
        ST_SPD_DIV,
        ST_SPD_STORE,
        ST_DIST_MUL,
        ST_DIST_SUM,
        ST_DIST_START,
        ST_DIST_DIV,
        ST_DIST_STORE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic clear_sums;
        logic first;
        logic update;
        logic spd_mul;
        logic div_start;
        logic spd_store;
        logic dist_mul;
        logic dist_sum;
        logic dist_store;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic clear_op;
        logic started;
        logic interval_ok;
        logic div_done;
    } t_sts;

endpackage

[hw/rtl/dual_encoder_speed_distance.sv]
// channel    dir  handshake                         payload
// s_axis     in   i_s_axis_tvalid / o_s_axis_tready tdata: now_ms, left_count, right_count
//                                                   tuser: op
// m_axis     out  o_m_axis_tvalid / i_m_axis_tready tdata: speeds left/right, dist left/right
//                                                   tuser: updated
// cfg        in   i_cfg_valid / o_cfg_ready         i_cfg_index, i_cfg_data
//
// one request at a time; both wheels share the controller and run two dividers side by side
// with NW = max(SUM_WIDTH + 20, 32 + SPEED_FRAC_BITS), 60 at defaults, one quotient bit a cycle
// accepted sample: speed division, then distance division, then the output register is loaded
// clear, first or too-early request: only the distance division before the output register is loaded
// result sits in an output register; the next request is taken while it waits
// synchronous active-low reset restores configuration and state defaults
module dual_encoder_speed_distance #(
    parameter int SPEED_FRAC_BITS = des_pkg::SPEED_FRAC_BITS_DEF,
    parameter int SUM_WIDTH       = des_pkg::SUM_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // now_ms [31:0], left_count [47:32], right_count [63:48]
    input  logic [des_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // op
    input  logic                            i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // left_speed_q8 [31:0], right_speed_q8 [63:32], left_dist_um [111:64],
    // right_dist_um [159:112]
    output logic [des_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // updated
    output logic                            o_m_axis_tuser,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [des_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [des_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    des_pkg::t_cmd cmd;
    des_pkg::t_sts sts;

    assign o_cfg_ready = 1'b1;

    des_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_axis_tvalid),
        .o_s_ready (o_s_axis_tready),
        .i_m_ready (i_m_axis_tready),
        .o_m_valid (o_m_axis_tvalid),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    des_dpath #(
        .SPEED_FRAC_BITS (SPEED_FRAC_BITS),
        .SUM_WIDTH       (SUM_WIDTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_s_axis_tdata),
        .i_in_user   (i_s_axis_tuser),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_data  (o_m_axis_tdata),
        .o_out_user  (o_m_axis_tuser)
    );

endmodule

[hw/rtl/des_div.sv]
module des_div #(
    parameter int NUM_W = 60,
    parameter int DEN_W = 48
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quo,
    output logic             o_done
);

    localparam int CNT_BITS = $clog2(NUM_W + 1);

    logic [DEN_W-1:0]    r_rem;
    logic [DEN_W-1:0]    r_den;
    logic [NUM_W-1:0]    r_quo;
    logic [CNT_BITS-1:0] r_cnt;
    logic                r_done;

    logic [DEN_W:0]      trial;
    logic [DEN_W:0]      diff;
    logic                fits;
    logic [DEN_W-1:0]    n_rem;
    logic [NUM_W-1:0]    n_quo;

    // restoring division, one quotient bit per cycle
    always_comb begin
        trial = {r_rem, r_quo[NUM_W-1]};
        fits  = trial >= {1'b0, r_den};
        diff  = trial - {1'b0, r_den};
        n_rem = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        n_quo = {r_quo[NUM_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= CNT_BITS'(NUM_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_cnt != '0) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

endmodule

[hw/rtl/des_dpath.sv]
module des_dpath #(
    parameter int SPEED_FRAC_BITS = des_pkg::SPEED_FRAC_BITS_DEF,
    parameter int SUM_WIDTH       = des_pkg::SUM_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  des_pkg::t_cmd                   i_cmd,
    output des_pkg::t_sts                   o_sts,
    input  logic [des_pkg::IN_DATA_W-1:0]   i_in_data,
    input  logic                            i_in_user,
    input  logic                            i_cfg_we,
    input  logic [des_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [des_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic [des_pkg::OUT_DATA_W-1:0]  o_out_data,
    output logic                            o_out_user
);

    localparam int CNT_W      = des_pkg::CNT_W;
    localparam int TIME_W     = des_pkg::TIME_W;
    localparam int CPR_W      = des_pkg::CPR_W;
    localparam int MINI_W     = des_pkg::MINI_W;
    localparam int CIRC_W     = des_pkg::CIRC_W;
    localparam int SPEED_W    = des_pkg::SPEED_W;
    localparam int DIST_W     = des_pkg::DIST_W;
    localparam int DEN_W      = des_pkg::DEN_W;
    localparam int SW         = SUM_WIDTH;
    localparam int SPD_PROD_W = CNT_W + des_pkg::RPM_SCALE_W;
    localparam int SPD_NUM_W  = SPD_PROD_W + SPEED_FRAC_BITS;
    localparam int DIST_NUM_W = SW + CIRC_W;
    localparam int NUM_W      = (SPD_NUM_W > DIST_NUM_W) ? SPD_NUM_W : DIST_NUM_W;
    localparam int CMP_W      = (NUM_W > DIST_W) ? NUM_W : DIST_W;
    localparam int LO_W       = SW / 2;
    localparam int HI_W       = SW - LO_W;
    localparam int PLO_W      = LO_W + CIRC_W;
    localparam int PHI_W      = HI_W + CIRC_W;

    localparam logic [CMP_W-1:0]   SPD_NEG_LIM  = CMP_W'(1) << (SPEED_W - 1);
    localparam logic [CMP_W-1:0]   SPD_POS_LIM  = SPD_NEG_LIM - CMP_W'(1);
    localparam logic [CMP_W-1:0]   DIST_NEG_LIM = CMP_W'(1) << (DIST_W - 1);
    localparam logic [CMP_W-1:0]   DIST_POS_LIM = DIST_NEG_LIM - CMP_W'(1);
    localparam logic [SPEED_W-1:0] SPD_MIN      = {1'b1, {(SPEED_W-1){1'b0}}};
    localparam logic [SPEED_W-1:0] SPD_MAX      = {1'b0, {(SPEED_W-1){1'b1}}};

    // configuration
    logic [CPR_W-1:0]   r_cpr;
    logic [MINI_W-1:0]  r_mini;
    logic [CIRC_W-1:0]  r_circ;
    logic               r_inv;

    // captured request
    logic               r_in_op;
    logic [TIME_W-1:0]  r_in_time;
    logic [CNT_W-1:0]   r_in_left;
    logic [CNT_W-1:0]   r_in_right;

    // block state
    logic               r_started;
    logic [TIME_W-1:0]  r_last_time;
    logic [CNT_W-1:0]   r_last_left;
    logic [CNT_W-1:0]   r_last_right;
    logic [SPEED_W-1:0] r_lspd;
    logic [SPEED_W-1:0] r_rspd;
    logic [SW-1:0]      r_lsum;
    logic [SW-1:0]      r_rsum;

    // working registers
    logic [CNT_W-1:0]   r_ldelta;
    logic [CNT_W-1:0]   r_rdelta;
    logic               r_updated;
    logic               r_lneg;
    logic               r_rneg;
    logic [NUM_W-1:0]   r_num_l;
    logic [NUM_W-1:0]   r_num_r;
    logic [DEN_W-1:0]   r_den;
    logic [PLO_W-1:0]   r_plo_l;
    logic [PHI_W-1:0]   r_phi_l;
    logic [PLO_W-1:0]   r_plo_r;
    logic [PHI_W-1:0]   r_phi_r;
    logic [DIST_W-1:0]  r_ldist;
    logic [DIST_W-1:0]  r_rdist;
    logic [des_pkg::OUT_DATA_W-1:0] r_out_data;
    logic               r_out_user;

    logic [CPR_W-1:0]      cpr_eff;
    logic [MINI_W-1:0]     mini_eff;
    logic [TIME_W-1:0]     dt;
    logic [CNT_W-1:0]      dmag_l;
    logic [CNT_W-1:0]      dmag_r;
    logic [SPD_PROD_W-1:0] spd_prod_l;
    logic [SPD_PROD_W-1:0] spd_prod_r;
    logic [DEN_W-1:0]      den_spd;
    logic [SW-1:0]         smag_l;
    logic [SW-1:0]         smag_r;
    logic [PLO_W-1:0]      plo_l;
    logic [PHI_W-1:0]      phi_l;
    logic [PLO_W-1:0]      plo_r;
    logic [PHI_W-1:0]      phi_r;
    logic [NUM_W-1:0]      dist_num_l;
    logic [NUM_W-1:0]      dist_num_r;
    logic [SPEED_W-1:0]    lsp_out;
    logic [NUM_W-1:0]      quo_l;
    logic [NUM_W-1:0]      quo_r;
    logic                  done_l;
    logic                  done_r;

    function automatic logic [SW-1:0] f_sum_add(input logic [SW-1:0] s,
                                                input logic [CNT_W-1:0] d);
        logic [SW:0]   v;
        logic [SW-1:0] r;
        v = {s[SW-1], s} + {{(SW+1-CNT_W){d[CNT_W-1]}}, d};
        if (v[SW] != v[SW-1]) begin
            r = v[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end else begin
            r = v[SW-1:0];
        end
        return r;
    endfunction

    function automatic logic [SPEED_W-1:0] f_spd_sat(input logic [NUM_W-1:0] q,
                                                     input logic neg);
        logic [CMP_W-1:0]   qx;
        logic [SPEED_W-1:0] r;
        qx = CMP_W'(q);
        if (neg) begin
            r = (qx > SPD_NEG_LIM) ? SPD_MIN : (SPEED_W'(0) - qx[SPEED_W-1:0]);
        end else begin
            r = (qx > SPD_POS_LIM) ? SPD_MAX : qx[SPEED_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [DIST_W-1:0] f_dist_sat(input logic [NUM_W-1:0] q,
                                                     input logic neg);
        logic [CMP_W-1:0]  qx;
        logic [CMP_W-1:0]  lim;
        logic [CMP_W-1:0]  m;
        logic [DIST_W-1:0] r;
        qx  = CMP_W'(q);
        lim = neg ? DIST_NEG_LIM : DIST_POS_LIM;
        m   = (qx > lim) ? lim : qx;
        r   = neg ? (DIST_W'(0) - m[DIST_W-1:0]) : m[DIST_W-1:0];
        return r;
    endfunction

    always_comb begin
        cpr_eff    = (r_cpr == '0) ? CPR_W'(1) : r_cpr;
        mini_eff   = (r_mini == '0) ? MINI_W'(1) : r_mini;
        dt         = r_in_time - r_last_time;
        dmag_l     = r_ldelta[CNT_W-1] ? (CNT_W'(0) - r_ldelta) : r_ldelta;
        dmag_r     = r_rdelta[CNT_W-1] ? (CNT_W'(0) - r_rdelta) : r_rdelta;
        spd_prod_l = SPD_PROD_W'(dmag_l) * SPD_PROD_W'(des_pkg::RPM_SCALE);
        spd_prod_r = SPD_PROD_W'(dmag_r) * SPD_PROD_W'(des_pkg::RPM_SCALE);
        den_spd    = DEN_W'(cpr_eff) * DEN_W'(dt);
        smag_l     = r_lsum[SW-1] ? (SW'(0) - r_lsum) : r_lsum;
        smag_r     = r_rsum[SW-1] ? (SW'(0) - r_rsum) : r_rsum;
        plo_l      = PLO_W'(smag_l[LO_W-1:0]) * PLO_W'(r_circ);
        phi_l      = PHI_W'(smag_l[SW-1:LO_W]) * PHI_W'(r_circ);
        plo_r      = PLO_W'(smag_r[LO_W-1:0]) * PLO_W'(r_circ);
        phi_r      = PHI_W'(smag_r[SW-1:LO_W]) * PHI_W'(r_circ);
        dist_num_l = NUM_W'(r_plo_l) + (NUM_W'(r_phi_l) << LO_W);
        dist_num_r = NUM_W'(r_plo_r) + (NUM_W'(r_phi_r) << LO_W);
        if (r_inv) begin
            lsp_out = (r_lspd == SPD_MIN) ? SPD_MAX : (SPEED_W'(0) - r_lspd);
        end else begin
            lsp_out = r_lspd;
        end
    end

    assign o_sts.clear_op    = (r_in_op == des_pkg::OP_CLEAR);
    assign o_sts.started     = r_started;
    assign o_sts.interval_ok = (dt >= TIME_W'(mini_eff));
    assign o_sts.div_done    = done_l & done_r;

    des_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div_l (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_num_l),
        .i_den   (r_den),
        .o_quo   (quo_l),
        .o_done  (done_l)
    );

    des_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div_r (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_num_r),
        .i_den   (r_den),
        .o_quo   (quo_r),
        .o_done  (done_r)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpr  <= des_pkg::CPR_RST;
            r_mini <= des_pkg::MINI_RST;
            r_circ <= des_pkg::CIRC_RST;
            r_inv  <= des_pkg::INV_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                des_pkg::CFG_CPR:      r_cpr  <= i_cfg_data[CPR_W-1:0];
                des_pkg::CFG_MIN_INT:  r_mini <= i_cfg_data[MINI_W-1:0];
                des_pkg::CFG_CIRC:     r_circ <= i_cfg_data[CIRC_W-1:0];
                des_pkg::CFG_INV_LEFT: r_inv  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started    <= 1'b0;
            r_last_time  <= '0;
            r_last_left  <= des_pkg::LAST_CNT_RST;
            r_last_right <= des_pkg::LAST_CNT_RST;
            r_lspd       <= '0;
            r_rspd       <= '0;
            r_lsum       <= '0;
            r_rsum       <= '0;
        end else begin
            if (i_cmd.first || i_cmd.update) begin
                r_last_time  <= r_in_time;
                r_last_left  <= r_in_left;
                r_last_right <= r_in_right;
            end
            if (i_cmd.first) begin
                r_started <= 1'b1;
                r_lspd    <= '0;
                r_rspd    <= '0;
            end
            if (i_cmd.clear_sums) begin
                r_lsum <= '0;
                r_rsum <= '0;
            end else if (i_cmd.spd_mul) begin
                r_lsum <= f_sum_add(r_lsum, r_ldelta);
                r_rsum <= f_sum_add(r_rsum, r_rdelta);
            end
            if (i_cmd.spd_store) begin
                r_lspd <= f_spd_sat(quo_l, r_lneg);
                r_rspd <= f_spd_sat(quo_r, r_rneg);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_in_op    <= i_in_user;
            r_in_time  <= i_in_data[TIME_W-1:0];
            r_in_left  <= i_in_data[TIME_W+CNT_W-1:TIME_W];
            r_in_right <= i_in_data[TIME_W+2*CNT_W-1:TIME_W+CNT_W];
            r_updated  <= 1'b0;
        end
        if (i_cmd.update) begin
            r_ldelta  <= r_in_left - r_last_left;
            r_rdelta  <= r_in_right - r_last_right;
            r_den     <= den_spd;
            r_updated <= 1'b1;
        end
        if (i_cmd.spd_mul) begin
            r_num_l <= NUM_W'(spd_prod_l) << SPEED_FRAC_BITS;
            r_num_r <= NUM_W'(spd_prod_r) << SPEED_FRAC_BITS;
            r_lneg  <= r_ldelta[CNT_W-1];
            r_rneg  <= r_rdelta[CNT_W-1];
        end
        if (i_cmd.dist_mul) begin
            r_plo_l <= plo_l;
            r_phi_l <= phi_l;
            r_plo_r <= plo_r;
            r_phi_r <= phi_r;
            r_lneg  <= r_lsum[SW-1];
            r_rneg  <= r_rsum[SW-1];
        end
        if (i_cmd.dist_sum) begin
            r_num_l <= dist_num_l;
            r_num_r <= dist_num_r;
            r_den   <= DEN_W'(cpr_eff);
        end
        if (i_cmd.dist_store) begin
            r_ldist <= f_dist_sat(quo_l, r_lneg);
            r_rdist <= f_dist_sat(quo_r, r_rneg);
        end
        if (i_cmd.load_out) begin
            r_out_data <= {r_rdist, r_ldist, r_rspd, lsp_out};
            r_out_user <= r_updated;
        end
    end

    assign o_out_data = r_out_data;
    assign o_out_user = r_out_user;

endmodule

[hw/rtl/des_ctrl.sv]
module des_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_valid,
    output logic           o_s_ready,
    input  logic           i_m_ready,
    output logic           o_m_valid,
    input  des_pkg::t_sts  i_sts,
    output des_pkg::t_cmd  o_cmd
);

    des_pkg::t_state r_state;
    des_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            des_pkg::ST_IDLE: begin
                if (i_s_valid) begin
                    n_state = des_pkg::ST_CHECK;
                end
            end
            des_pkg::ST_CHECK: begin
                if (!i_sts.clear_op && i_sts.started && i_sts.interval_ok) begin
                    n_state = des_pkg::ST_SPD_MUL;
                end else begin
                    n_state = des_pkg::ST_DIST_MUL;
                end
            end
            des_pkg::ST_SPD_MUL:   n_state = des_pkg::ST_SPD_START;
            des_pkg::ST_SPD_START: n_state = des_pkg::ST_SPD_DIV;
            des_pkg::ST_SPD_DIV: begin
                if (i_sts.div_done) begin
                    n_state = des_pkg::ST_SPD_STORE;
                end
            end
            des_pkg::ST_SPD_STORE:  n_state = des_pkg::ST_DIST_MUL;
            des_pkg::ST_DIST_MUL:   n_state = des_pkg::ST_DIST_SUM;
            des_pkg::ST_DIST_SUM:   n_state = des_pkg::ST_DIST_START;
            des_pkg::ST_DIST_START: n_state = des_pkg::ST_DIST_DIV;
            des_pkg::ST_DIST_DIV: begin
                if (i_sts.div_done) begin
                    n_state = des_pkg::ST_DIST_STORE;
                end
            end
            des_pkg::ST_DIST_STORE: n_state = des_pkg::ST_OUT;
            des_pkg::ST_OUT: begin
                if (!r_out_valid || i_m_ready) begin
                    n_state = des_pkg::ST_IDLE;
                end
            end
            default: n_state = des_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd     = '0;
        o_s_ready = 1'b0;
        case (r_state)
            des_pkg::ST_IDLE: begin
                o_s_ready     = 1'b1;
                o_cmd.capture = i_s_valid;
            end
            des_pkg::ST_CHECK: begin
                if (i_sts.clear_op) begin
                    o_cmd.clear_sums = 1'b1;
                end else if (!i_sts.started) begin
                    o_cmd.first = 1'b1;
                end else if (i_sts.interval_ok) begin
                    o_cmd.update = 1'b1;
                end
            end
            des_pkg::ST_SPD_MUL:    o_cmd.spd_mul    = 1'b1;
            des_pkg::ST_SPD_START:  o_cmd.div_start  = 1'b1;
            des_pkg::ST_SPD_STORE:  o_cmd.spd_store  = 1'b1;
            des_pkg::ST_DIST_MUL:   o_cmd.dist_mul   = 1'b1;
            des_pkg::ST_DIST_SUM:   o_cmd.dist_sum   = 1'b1;
            des_pkg::ST_DIST_START: o_cmd.div_start  = 1'b1;
            des_pkg::ST_DIST_STORE: o_cmd.dist_store = 1'b1;
            des_pkg::ST_OUT:        o_cmd.load_out   = !r_out_valid || i_m_ready;
            default: ;
        endcase
    end

    assign n_out_valid = o_cmd.load_out ? 1'b1 : (i_m_ready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= des_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_m_valid = r_out_valid;

endmodule

[hw/rtl/des_checker.sv]
module des_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    input  logic                            o_s_axis_tready,
    input  logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    input  logic [des_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    input  logic                            o_m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result changed while stalled");

    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second request taken while one is in work");

    a_result_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> o_s_axis_tready)
        else $error("not ready for a request after a result");

endmodule

bind dual_encoder_speed_distance des_checker u_des_checker (.*);
